// ----- hdl/rts_pkg.sv -----
// Package for the read-transfer sender: command, packet, error and status codes,
// register indexes, reset values and the word layouts of both channels.
// No dependencies.
package rts_pkg;

  localparam int unsigned BLK_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [BLK_W-1:0] ACK_PRESET = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PKT_NONE  = 2'd0,
    PKT_DATA  = 2'd1,
    PKT_OACK  = 2'd2,
    PKT_ERROR = 2'd3
  } pkt_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_OPTION  = 2'd1,
    ERR_ILLEGAL = 2'd2
  } err_code_e;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLKSIZE_EN    = 3'd0,
    REG_BLKSIZE_LIMIT = 3'd1,
    REG_TIMEOUT_EN    = 3'd2,
    REG_TSIZE_EN      = 3'd3,
    REG_DATA_BLK_SIZE = 3'd4
  } reg_idx_e;

  localparam logic [15:0] BLKSIZE_LIMIT_RST = 16'd1428;
  localparam logic [15:0] DATA_BLK_SIZE_RST = 16'd512;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [BLK_W-1:0] ack_block;
    logic [15:0]      chunk_len;
    logic             extra_opts_present;
    logic             blksize_req_valid;
    logic [15:0]      blksize_req;
    logic             timeout_req_valid;
    logic [7:0]       timeout_req;
    logic             tsize_req_valid;
    logic             tsize_req_nonzero;
    logic             tsize_known;
  } rts_in_t;

  typedef struct packed {
    logic [1:0]       pkt_kind;
    logic [BLK_W-1:0] data_block_num;
    logic             data_last;
    logic [1:0]       err_code;
    logic             oack_blksize_inc;
    logic [15:0]      oack_blksize;
    logic             oack_timeout_inc;
    logic [7:0]       oack_timeout;
    logic             oack_tsize_inc;
    logic [1:0]       status;
  } rts_out_t;

endpackage

// ----- hdl/rts_in_if.sv -----
// Event channel into the read-transfer sender: valid, ready and one event word.
// Depends on rts_pkg.
interface rts_in_if;
  import rts_pkg::*;

  logic    valid;
  logic    ready;
  rts_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/rts_out_if.sv -----
// Result channel out of the read-transfer sender: valid, ready and one result word.
// Depends on rts_pkg.
interface rts_out_if;
  import rts_pkg::*;

  logic     valid;
  logic     ready;
  rts_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/tftp_read_transfer_sender_core.sv -----
// A result word is registered and valid in the cycle after its event word is accepted.
// Throughput: one event word per cycle while the result channel is ready; the single
// result register is refilled in the same cycle that its word is taken.
// Reset clears the block counters, the end flags, the result valid flag and
// restores the configuration registers to their defaults.
// Sender side of a read transfer; depends on rts_pkg, rts_in_if and rts_out_if.
module tftp_read_transfer_sender_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rts_pkg::CFG_W-1:0]        cfg_data_i,
  rts_in_if.sink                           in_i,
  rts_out_if.source                        out_o
);
  import rts_pkg::*;

  logic             blksize_en_q;
  logic [15:0]      blksize_limit_q;
  logic             timeout_en_q;
  logic             tsize_en_q;
  logic [15:0]      data_blk_size_q;

  logic [BLK_W-1:0] sent_q, sent_d;
  logic [BLK_W-1:0] acked_q, acked_d;
  logic             last_q, last_d;
  logic             done_q, done_d;

  rts_out_t         out_q, out_d;
  logic             out_valid_q;

  rts_in_t          item;
  logic             in_acc;
  logic             bs_inc, to_inc, ts_inc;
  logic [BLK_W-1:0] sent_inc;
  logic             chunk_short;

  assign item        = in_i.data;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blksize_en_q    <= 1'b0;
      blksize_limit_q <= BLKSIZE_LIMIT_RST;
      timeout_en_q    <= 1'b0;
      tsize_en_q      <= 1'b0;
      data_blk_size_q <= DATA_BLK_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLKSIZE_EN:    blksize_en_q    <= cfg_data_i[0];
        REG_BLKSIZE_LIMIT: blksize_limit_q <= cfg_data_i[15:0];
        REG_TIMEOUT_EN:    timeout_en_q    <= cfg_data_i[0];
        REG_TSIZE_EN:      tsize_en_q      <= cfg_data_i[0];
        REG_DATA_BLK_SIZE: data_blk_size_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sent_d      = sent_q;
    acked_d     = acked_q;
    last_d      = last_q;
    done_d      = done_q;
    out_d       = '0;
    bs_inc      = blksize_en_q && item.blksize_req_valid;
    to_inc      = timeout_en_q && item.timeout_req_valid;
    ts_inc      = tsize_en_q && item.tsize_req_valid && item.tsize_known;
    chunk_short = item.chunk_len < data_blk_size_q;
    sent_inc    = sent_q + BLK_W'(1);

    case (item.cmd)
      CMD_START: begin
        sent_d  = '0;
        acked_d = '0;
        last_d  = 1'b0;
        done_d  = 1'b0;
        if (tsize_en_q && item.tsize_req_valid && item.tsize_req_nonzero) begin
          out_d.pkt_kind = PKT_ERROR;
          out_d.err_code = ERR_OPTION;
          out_d.status   = ST_ERROR;
          done_d         = 1'b1;
        end else if (item.extra_opts_present || bs_inc || to_inc || ts_inc) begin
          acked_d                = ACK_PRESET;
          out_d.pkt_kind         = PKT_OACK;
          out_d.oack_blksize_inc = bs_inc;
          out_d.oack_timeout_inc = to_inc;
          out_d.oack_tsize_inc   = ts_inc;
          if (bs_inc) begin
            out_d.oack_blksize = (item.blksize_req < blksize_limit_q) ?
                                 item.blksize_req : blksize_limit_q;
          end
          if (to_inc) begin
            out_d.oack_timeout = item.timeout_req;
          end
        end else begin
          sent_d               = BLK_W'(1);
          last_d               = chunk_short;
          out_d.pkt_kind       = PKT_DATA;
          out_d.data_block_num = BLK_W'(1);
          out_d.data_last      = chunk_short;
        end
      end
      CMD_DATA: begin
        if (!done_q) begin
          out_d.pkt_kind = PKT_ERROR;
          out_d.err_code = ERR_ILLEGAL;
          out_d.status   = ST_ERROR;
          done_d         = 1'b1;
        end
      end
      CMD_ACK: begin
        if (!done_q && (item.ack_block != acked_q)) begin
          if (item.ack_block != sent_q) begin
            out_d.pkt_kind = PKT_ERROR;
            out_d.err_code = ERR_ILLEGAL;
            out_d.status   = ST_ERROR;
            done_d         = 1'b1;
          end else begin
            acked_d = item.ack_block;
            if (last_q) begin
              out_d.status = ST_SUCCESS;
              done_d       = 1'b1;
            end else begin
              sent_d               = sent_inc;
              last_d               = chunk_short;
              out_d.pkt_kind       = PKT_DATA;
              out_d.data_block_num = sent_inc;
              out_d.data_last      = chunk_short;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      acked_q     <= '0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        sent_q  <= sent_d;
        acked_q <= acked_d;
        last_q  <= last_d;
        done_q  <= done_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("Accepted event word produced no result word.");

  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && done_q && (item.cmd != CMD_START) |=>
      (out_q.pkt_kind == PKT_NONE) && (out_q.status == ST_RUNNING))
    else $error("Event after the end of a transfer produced a packet.");

  a_done_by_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(in_acc))
    else $error("Transfer ended without an accepted event.");

  a_start_end_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (item.cmd == CMD_START) |=> !done_q || (out_q.pkt_kind == PKT_ERROR))
    else $error("Start ended a transfer without an error packet.");

  a_data_tracks_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_q.pkt_kind != PKT_DATA) || (out_q.data_block_num == sent_q))
    else $error("Data block number differs from the sent block counter.");

endmodule
